>>> sv/idxalloc_pkg.sv
// Shared types and constants for the index allocator with recycle FIFO.
package idxalloc_pkg;

    localparam int INDEX_BITS = 12;
    localparam int GROUP_BITS = 4;
    localparam int ID_BITS    = GROUP_BITS + INDEX_BITS;
    localparam int COUNT_BITS = INDEX_BITS + 1;
    localparam int DEPTH      = 1 << INDEX_BITS;

    localparam logic [ID_BITS-1:0]    ID_INVALID = {ID_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] DEPTH_CNT  = COUNT_BITS'(DEPTH);

    // Reset values of the configuration registers
    localparam logic [GROUP_BITS-1:0] GROUP_RST = '0;
    localparam logic [INDEX_BITS-1:0] MIN_RST   = INDEX_BITS'(1);
    localparam logic [COUNT_BITS-1:0] MAX_RST   = COUNT_BITS'(DEPTH - 1);

    // Operation codes
    localparam logic OP_GEN  = 1'b0;
    localparam logic OP_FREE = 1'b1;

    // Register indexes on the APB port (byte address / 4)
    localparam int              ADDR_BITS = 4;
    localparam logic [1:0]      REG_GROUP = 2'd0;
    localparam logic [1:0]      REG_MIN   = 2'd1;
    localparam logic [1:0]      REG_MAX   = 2'd2;

    typedef struct packed {
        logic                 operation;
        logic [ID_BITS-1:0]   id;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic                  done_op;
        logic                  ok;
        logic [ID_BITS-1:0]    new_id;
        logic [COUNT_BITS-1:0] next_fresh;
        logic [COUNT_BITS-1:0] recycled_count;
    } t_res;

endpackage

>>> sv/index_allocator_with_recycle_fifo.sv
// Top level: id allocator with fresh counter and transactional recycle FIFO.
// A result is registered and appears in the cycle after its command beat is accepted.
// Throughput: one command per cycle; busy is never raised, the single-port
// recycle RAM sees at most one pop read or one push write per cycle.
// Reset (i_rst_n low, synchronous) empties the FIFO and reloads the config
// registers; RAM contents are not cleared, stale slots are never read.
// The result is a one-cycle strobe; the receiver cannot stall it.
module index_allocator_with_recycle_fifo (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  idxalloc_pkg::t_cmd                    i_cmd,
    // result channel
    output logic                                  o_res_valid,
    output idxalloc_pkg::t_res                    o_res,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [idxalloc_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int IB = idxalloc_pkg::INDEX_BITS;
    localparam int GB = idxalloc_pkg::GROUP_BITS;
    localparam int CB = idxalloc_pkg::COUNT_BITS;

    // ---------------- configuration registers ----------------
    logic [GB-1:0] r_group;
    logic [IB-1:0] r_min;
    logic [CB-1:0] r_max;

    // ---------------- allocator state ----------------
    logic [CB-1:0] r_fresh,   n_fresh;
    logic [IB-1:0] r_head,    n_head;
    logic [IB-1:0] r_ctail,   n_ctail;   // committed tail
    logic [IB-1:0] r_ttail,   n_ttail;   // tentative tail
    logic [CB-1:0] r_ccount,  n_ccount;  // committed entries
    logic [CB-1:0] r_pcount,  n_pcount;  // pending entries of the open batch
    logic          r_bfail,   n_bfail;

    // recycle RAM, one port: pop read or push write
    logic [IB-1:0] r_mem [idxalloc_pkg::DEPTH];
    logic [IB-1:0] r_mem_q;

    // result register
    logic          r_valid,   n_valid;
    logic          r_pop,     n_pop;     // new_id comes from the RAM read
    logic [GB-1:0] r_grp_q;
    idxalloc_pkg::t_res r_res, n_res;

    logic          accept;
    logic          cfg_we;
    logic [1:0]    cfg_idx;
    logic          mem_we;
    logic          mem_re;

    // free-path checks
    logic [GB-1:0] free_grp;
    logic [IB-1:0] free_idx;
    logic          free_valid;
    logic [CB:0]   fill;
    logic          fifo_full;
    logic          gen_fail;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign accept  = start & ~busy;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];

    assign free_grp   = i_cmd.id[idxalloc_pkg::ID_BITS-1:IB];
    assign free_idx   = i_cmd.id[IB-1:0];
    assign free_valid = (i_cmd.id != idxalloc_pkg::ID_INVALID) && (free_grp == r_group)
                        && ({1'b0, free_idx} < r_fresh);
    assign fill       = {1'b0, r_ccount} + {1'b0, r_pcount};
    assign fifo_full  = fill >= {1'b0, idxalloc_pkg::DEPTH_CNT};
    // limit saturates at the index range (top counter bit set)
    assign gen_fail   = (r_fresh >= r_max) || r_fresh[CB-1];

    // ---------------- APB read ----------------
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            idxalloc_pkg::REG_GROUP: prdata = 32'(r_group);
            idxalloc_pkg::REG_MIN:   prdata = 32'(r_min);
            idxalloc_pkg::REG_MAX:   prdata = 32'(r_max);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- command decode / next state ----------------
    always_comb begin
        n_fresh  = r_fresh;
        n_head   = r_head;
        n_ctail  = r_ctail;
        n_ttail  = r_ttail;
        n_ccount = r_ccount;
        n_pcount = r_pcount;
        n_bfail  = r_bfail;
        n_valid  = 1'b0;
        n_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        n_res    = '0;

        if (accept) begin
            if (i_cmd.operation == idxalloc_pkg::OP_GEN) begin
                n_valid = 1'b1;
                if (r_ccount != '0) begin
                    // oldest committed entry; id completed when RAM data returns
                    mem_re   = 1'b1;
                    n_pop    = 1'b1;
                    n_head   = r_head + IB'(1);
                    n_ccount = r_ccount - CB'(1);
                    n_res.ok = 1'b1;
                end else if (gen_fail) begin
                    n_res.new_id = idxalloc_pkg::ID_INVALID;
                end else begin
                    n_res.new_id = {r_group, r_fresh[IB-1:0]};
                    n_fresh      = r_fresh + CB'(1);
                    n_res.ok     = 1'b1;
                end
            end else begin
                if (!free_valid || fifo_full) begin
                    n_bfail = 1'b1;
                end else begin
                    mem_we   = 1'b1;
                    n_ttail  = r_ttail + IB'(1);
                    n_pcount = r_pcount + CB'(1);
                end
                if (i_cmd.last) begin
                    n_valid = 1'b1;
                    if (!n_bfail) begin
                        n_ctail  = n_ttail;
                        n_ccount = r_ccount + n_pcount;
                        n_res.ok = 1'b1;
                    end else begin
                        n_ttail = r_ctail;  // roll back the batch
                    end
                    n_pcount = '0;
                    n_bfail  = 1'b0;
                end
            end
            n_res.done_op        = i_cmd.operation;
            n_res.next_fresh     = n_fresh;
            n_res.recycled_count = n_ccount;
        end

        // a min_index write reloads the fresh counter
        if (cfg_we && cfg_idx == idxalloc_pkg::REG_MIN) begin
            n_fresh = {1'b0, pwdata[IB-1:0]};
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group  <= idxalloc_pkg::GROUP_RST;
            r_min    <= idxalloc_pkg::MIN_RST;
            r_max    <= idxalloc_pkg::MAX_RST;
            r_fresh  <= {1'b0, idxalloc_pkg::MIN_RST};
            r_head   <= '0;
            r_ctail  <= '0;
            r_ttail  <= '0;
            r_ccount <= '0;
            r_pcount <= '0;
            r_bfail  <= 1'b0;
            r_valid  <= 1'b0;
            r_pop    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    idxalloc_pkg::REG_GROUP: r_group <= pwdata[GB-1:0];
                    idxalloc_pkg::REG_MIN:   r_min   <= pwdata[IB-1:0];
                    idxalloc_pkg::REG_MAX:   r_max   <= pwdata[CB-1:0];
                    default: ;
                endcase
            end
            r_fresh  <= n_fresh;
            r_head   <= n_head;
            r_ctail  <= n_ctail;
            r_ttail  <= n_ttail;
            r_ccount <= n_ccount;
            r_pcount <= n_pcount;
            r_bfail  <= n_bfail;
            r_valid  <= n_valid;
            r_pop    <= n_pop;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_grp_q <= r_group;
    end

    // recycle RAM: push writes at the tentative tail, pop reads at the head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_ttail] <= free_idx;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[r_head];
        end
    end

    // ---------------- result ----------------
    always_comb begin
        o_res = r_res;
        if (r_pop) begin
            o_res.new_id = {r_grp_q, r_mem_q};
        end
    end
    assign o_res_valid = r_valid;

endmodule
